/* src/joystick_view_cursor_accelerator_assert.svh */
// ----------------------------------------------------------------------------
// joystick view cursor accelerator assertion macros
// shared concurrent assertion forms, sampled on clk, idle during reset
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_VIEW_CURSOR_ACCELERATOR_ASSERT_SVH
`define JOYSTICK_VIEW_CURSOR_ACCELERATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define JVCA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("jvca assertion failed");

// antecedent implies consequent in the same cycle
`define JVCA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jvca assertion failed");

// antecedent implies consequent in the next cycle
`define JVCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jvca assertion failed");

`endif

/* src/jvca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvca_pkg
// shared types, constants and lookup functions of the view cursor accelerator
// ----------------------------------------------------------------------------
package jvca_pkg;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1200;
    localparam int HOLD_SAMPLES  = 10;

    localparam logic [7:0] CENTER_RAW = 8'd128;
    localparam logic [7:0] FLAT_LIMIT = 8'd23;
    localparam logic [7:0] WEAK_LIMIT = 8'd96;

    localparam logic [5:0] SUSTAIN_TOP   = 6'd60;
    localparam logic [5:0] SUSTAIN_WEAK  = 6'd15;
    localparam logic [2:0] STEP_WEAK     = 3'd2;
    localparam logic [2:0] STEP_AXIS_CAP = 3'd3;
    localparam logic [2:0] STEP_DIAG     = 3'd2;

    localparam logic [2:0] LEVEL_MIN = 3'd1;
    localparam logic [2:0] LEVEL_MAX = 3'd5;

    localparam logic [3:0]  HOLD_LIMIT  = 4'(HOLD_SAMPLES);
    localparam logic signed [12:0] POS_X_MIN = 13'(SCREEN_WIDTH / 2 + 2);
    localparam logic signed [12:0] POS_X_MAX = 13'(SCREEN_WIDTH);
    localparam logic signed [12:0] POS_Y_MAX = 13'(SCREEN_HEIGHT);

    localparam logic [2:0]  SPEED_RESET    = 3'd3;
    localparam logic [10:0] ORIGIN_X_RESET = 11'd1440;
    localparam logic [10:0] ORIGIN_Y_RESET = 11'd600;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SPEED_LEVEL = 2'd0,
        REG_ORIGIN_X    = 2'd1,
        REG_ORIGIN_Y    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  speed_level;
        logic [10:0] origin_x;
        logic [10:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        raw_h;
        logic [7:0]        raw_v;
        logic signed [8:0] off_h;
        logic signed [8:0] off_v;
        logic [2:0]        pacing;
        logic [5:0]        sustain;
        logic [7:0]        prev_mag;
        logic [10:0]       pos_x;
        logic [10:0]       pos_y;
        logic              wrapped;
        logic [3:0]        hold;
    } state_t;

    typedef struct packed {
        logic [10:0] cursor_x;
        logic [10:0] cursor_y;
        logic        contact_on;
        logic        bounds_hold;
    } result_t;

    // samples per cursor move for levels 1..5
    function automatic logic [3:0] pace_for(input logic [2:0] lvl);
        logic [3:0] pace;
        begin
            case (lvl)
                3'd1:    pace = 4'd8;
                3'd2:    pace = 4'd6;
                3'd3:    pace = 4'd3;
                3'd4:    pace = 4'd2;
                3'd5:    pace = 4'd1;
                default: pace = 4'd1;
            endcase
            return pace;
        end
    endfunction

    // step size from the sustained deflection count
    function automatic logic [2:0] step_for(input logic [5:0] s);
        logic [2:0] st;
        begin
            if (s < 6'd15)      st = 3'd1;
            else if (s < 6'd20) st = 3'd2;
            else if (s < 6'd30) st = 3'd3;
            else if (s < 6'd40) st = 3'd4;
            else if (s < 6'd50) st = 3'd5;
            else if (s < 6'd60) st = 3'd6;
            else                st = 3'd7;
            return st;
        end
    endfunction

endpackage

/* src/jvca_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvca_core
// single-pass update of the cursor state from one axis sample
// ----------------------------------------------------------------------------
module jvca_core (
    input  jvca_pkg::state_t  state_cur,
    input  jvca_pkg::cfg_t    cfg,
    input  logic              axis_select,
    input  logic [7:0]        axis_value,
    output jvca_pkg::state_t  state_nxt,
    output jvca_pkg::result_t result
);

    logic                centered;
    logic                zero_off;
    logic [7:0]          mag_h;
    logic [7:0]          mag_v;
    logic signed [8:0]   off_v_eff;
    logic [2:0]          lvl;
    logic [3:0]          pace;
    logic [3:0]          pace_cnt;
    logic                fire;
    logic [5:0]          sus_inc;
    logic [2:0]          step;
    logic [2:0]          dx;
    logic [2:0]          dy;
    logic [10:0]         base_x;
    logic [10:0]         base_y;
    logic signed [12:0]  px;
    logic signed [12:0]  py;
    logic                out_of_bounds;
    logic [3:0]          hold_inc;
    logic                contact;

    always_comb
    begin
        state_nxt     = state_cur;
        off_v_eff     = '0;
        lvl           = cfg.speed_level;
        pace          = '0;
        pace_cnt      = '0;
        fire          = 1'b0;
        sus_inc       = '0;
        step          = '0;
        dx            = '0;
        dy            = '0;
        px            = '0;
        py            = '0;
        out_of_bounds = 1'b0;
        hold_inc      = '0;
        contact       = 1'b0;

        // latch the new raw sample and its centered offset
        if (!axis_select)
        begin
            state_nxt.raw_h = axis_value;
            state_nxt.off_h = $signed({1'b0, axis_value})
                            - $signed({1'b0, jvca_pkg::CENTER_RAW});
        end
        else
        begin
            state_nxt.raw_v = axis_value;
            state_nxt.off_v = $signed({1'b0, axis_value})
                            - $signed({1'b0, jvca_pkg::CENTER_RAW});
        end

        // both raw axes centered sends the cursor home
        centered = (state_nxt.raw_h == jvca_pkg::CENTER_RAW)
                && (state_nxt.raw_v == jvca_pkg::CENTER_RAW);
        base_x = centered ? cfg.origin_x : state_cur.pos_x;
        base_y = centered ? cfg.origin_y : state_cur.pos_y;
        state_nxt.pos_x = base_x;
        state_nxt.pos_y = base_y;

        mag_h = state_nxt.off_h[8] ? 8'(-state_nxt.off_h) : state_nxt.off_h[7:0];
        mag_v = state_nxt.off_v[8] ? 8'(-state_nxt.off_v) : state_nxt.off_v[7:0];
        zero_off = (state_nxt.off_h == 9'sd0) && (state_nxt.off_v == 9'sd0);

        if (zero_off)
        begin
            state_nxt.sustain = '0;
        end
        else
        begin
            // small vertical deflection counts as horizontal
            off_v_eff = (mag_v < jvca_pkg::FLAT_LIMIT) ? 9'sd0 : state_nxt.off_v;
            state_nxt.off_v = off_v_eff;

            // pacing divider
            if (lvl < jvca_pkg::LEVEL_MIN)
                lvl = jvca_pkg::LEVEL_MIN;
            if (lvl > jvca_pkg::LEVEL_MAX)
                lvl = jvca_pkg::LEVEL_MAX;
            pace     = jvca_pkg::pace_for(lvl);
            pace_cnt = {1'b0, state_cur.pacing} + 4'd1;
            fire     = !(pace_cnt < pace);

            if (!fire)
            begin
                state_nxt.pacing = pace_cnt[2:0];
            end
            else
            begin
                state_nxt.pacing = '0;

                // acceleration from sustained deflection
                sus_inc = state_cur.sustain + 6'd1;
                step    = jvca_pkg::step_for(sus_inc);
                state_nxt.sustain = (sus_inc >= jvca_pkg::SUSTAIN_TOP) ?
                                    (sus_inc - 6'd1) : sus_inc;
                if ((mag_h < state_cur.prev_mag) || (mag_h < jvca_pkg::WEAK_LIMIT))
                begin
                    state_nxt.sustain = jvca_pkg::SUSTAIN_WEAK;
                    step = jvca_pkg::STEP_WEAK;
                end
                state_nxt.prev_mag = mag_h;

                // per-axis step with caps for vertical and diagonal moves
                if (off_v_eff == 9'sd0)
                begin
                    dx = step;
                end
                else if (state_nxt.off_h == 9'sd0)
                begin
                    dy = (step > jvca_pkg::STEP_AXIS_CAP) ? jvca_pkg::STEP_AXIS_CAP : step;
                end
                else
                begin
                    dx = (step > jvca_pkg::STEP_AXIS_CAP) ? jvca_pkg::STEP_DIAG : step;
                    dy = dx;
                end

                px = state_nxt.off_h[8] ? ($signed({2'b0, base_x}) - $signed({10'b0, dx}))
                                        : ($signed({2'b0, base_x}) + $signed({10'b0, dx}));
                py = off_v_eff[8] ? ($signed({2'b0, base_y}) - $signed({10'b0, dy}))
                                  : ($signed({2'b0, base_y}) + $signed({10'b0, dy}));

                // leaving the right-half bounds wraps to the origin
                out_of_bounds = (py > jvca_pkg::POS_Y_MAX) || py[12]
                             || (px < jvca_pkg::POS_X_MIN) || (px > jvca_pkg::POS_X_MAX);
                if (out_of_bounds)
                begin
                    state_nxt.pos_x   = cfg.origin_x;
                    state_nxt.pos_y   = cfg.origin_y;
                    state_nxt.wrapped = 1'b1;
                end
                else
                begin
                    state_nxt.pos_x = px[10:0];
                    state_nxt.pos_y = py[10:0];
                end
            end
        end

        // contact with post-wrap hold
        if (centered)
        begin
            contact = 1'b0;
        end
        else if (state_nxt.wrapped)
        begin
            hold_inc = state_cur.hold + 4'd1;
            if (hold_inc < jvca_pkg::HOLD_LIMIT)
            begin
                state_nxt.hold = hold_inc;
                contact = 1'b0;
            end
            else
            begin
                state_nxt.hold    = '0;
                state_nxt.wrapped = 1'b0;
                contact = 1'b1;
            end
        end
        else
        begin
            contact = 1'b1;
        end

        result.cursor_x    = state_nxt.pos_x;
        result.cursor_y    = state_nxt.pos_y;
        result.contact_on  = contact;
        result.bounds_hold = state_nxt.wrapped;
    end

endmodule

/* src/joystick_view_cursor_accelerator.sv */
`timescale 1ns / 1ps
// The result register loads from the input register through the update logic when the
// result side can advance. Throughput: one beat per cycle while out_ready holds; the
// cursor state updates in one pass per beat, set by that register to register path.
// Register writes wait while a sample beat sits in the input register.
// Reset: rst_n clears all control state, speed level 3, origin (1440, 600),
// cursor at the origin, contact hold cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// joystick_view_cursor_accelerator
// right-stick view cursor with pacing, acceleration and bounds wrap
// ----------------------------------------------------------------------------
`include "joystick_view_cursor_accelerator_assert.svh"

module joystick_view_cursor_accelerator (
    input  logic        clk,
    input  logic        rst_n,
    // sample channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        axis_select,
    input  logic [7:0]  axis_value,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cursor_x,
    output logic [10:0] cursor_y,
    output logic        contact_on,
    output logic        bounds_hold,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    logic               s1_valid_reg;
    logic               s1_select_reg;
    logic [7:0]         s1_value_reg;
    logic               out_valid_reg;
    jvca_pkg::result_t  result_reg;
    jvca_pkg::state_t   state_reg;
    jvca_pkg::state_t   state_next;
    jvca_pkg::cfg_t     cfg_reg;
    jvca_pkg::cfg_t     cfg_next;
    jvca_pkg::state_t   core_state;
    jvca_pkg::result_t  core_result;
    jvca_pkg::cfg_reg_t cfg_sel;
    logic               advance;
    logic               step_en;
    logic               cfg_wr;

    // handshake control
    assign advance   = !out_valid_reg || out_ready;
    assign step_en   = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = !s1_valid_reg;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_sel   = jvca_pkg::cfg_reg_t'(cfg_index);

    jvca_core u_core (
        .state_cur   (state_reg),
        .cfg         (cfg_reg),
        .axis_select (s1_select_reg),
        .axis_value  (s1_value_reg),
        .state_nxt   (core_state),
        .result      (core_result)
    );

    // state and configuration update
    always_comb
    begin
        state_next = state_reg;
        cfg_next   = cfg_reg;
        if (step_en)
        begin
            state_next = core_state;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                jvca_pkg::REG_SPEED_LEVEL:
                begin
                    cfg_next.speed_level = cfg_data[2:0];
                end
                jvca_pkg::REG_ORIGIN_X:
                begin
                    cfg_next.origin_x = cfg_data;
                    state_next.pos_x  = cfg_data;
                    state_next.pos_y  = cfg_reg.origin_y;
                end
                jvca_pkg::REG_ORIGIN_Y:
                begin
                    cfg_next.origin_y = cfg_data;
                    state_next.pos_x  = cfg_reg.origin_x;
                    state_next.pos_y  = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_level <= jvca_pkg::SPEED_RESET;
            cfg_reg.origin_x    <= jvca_pkg::ORIGIN_X_RESET;
            cfg_reg.origin_y    <= jvca_pkg::ORIGIN_Y_RESET;
            state_reg.raw_h     <= jvca_pkg::CENTER_RAW;
            state_reg.raw_v     <= jvca_pkg::CENTER_RAW;
            state_reg.off_h     <= '0;
            state_reg.off_v     <= '0;
            state_reg.pacing    <= '0;
            state_reg.sustain   <= '0;
            state_reg.prev_mag  <= '0;
            state_reg.pos_x     <= jvca_pkg::ORIGIN_X_RESET;
            state_reg.pos_y     <= jvca_pkg::ORIGIN_Y_RESET;
            state_reg.wrapped   <= 1'b0;
            state_reg.hold      <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_select_reg <= axis_select;
            s1_value_reg  <= axis_value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cursor_x    = result_reg.cursor_x;
    assign cursor_y    = result_reg.cursor_y;
    assign contact_on  = result_reg.contact_on;
    assign bounds_hold = result_reg.bounds_hold;

    // assertions
    `JVCA_ASSERT_IMPL(a_contact_not_held, out_valid_reg, !(contact_on && bounds_hold))
    `JVCA_ASSERT_IMPL(a_hold_needs_wrap, state_reg.hold != 4'd0, state_reg.wrapped)
    `JVCA_ASSERT_ALWAYS(a_sustain_range, state_reg.sustain < jvca_pkg::SUSTAIN_TOP)
    `JVCA_ASSERT_NEXT(a_no_phantom_result, !out_valid_reg && !s1_valid_reg, !out_valid_reg)

endmodule

/* dv/tb_joystick_view_cursor_accelerator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_view_cursor_accelerator
// drives stick samples and register writes into the view cursor accelerator,
// tracks the expected cursor, contact and hold in a local cursor predictor,
// and compares every result beat field by field under random stalls
// ----------------------------------------------------------------------------
module tb_joystick_view_cursor_accelerator;

    localparam logic       AXIS_H      = 1'b0;
    localparam logic       AXIS_V      = 1'b1;
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         SETTLE_PAD  = 4;
    localparam int         STUCK_LIMIT = 3000;
    localparam int         PRINT_CAP   = 40;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        axis_select;
    logic [7:0]  axis_value;
    logic        out_valid;
    logic        out_ready;
    logic [10:0] cursor_x;
    logic [10:0] cursor_y;
    logic        contact_on;
    logic        bounds_hold;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    // predictor copy of registers and cursor state
    logic [2:0]         pace_level;
    logic [10:0]        home_x;
    logic [10:0]        home_y;
    logic [7:0]         stick_h;
    logic [7:0]         stick_v;
    logic signed [8:0]  defl_h;
    logic signed [8:0]  defl_v;
    logic [2:0]         pace_cnt;
    logic [5:0]         sustain_cnt;
    logic [7:0]         last_mag;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;
    logic               wrapped;
    logic [3:0]         hold_cnt;

    jvca_pkg::result_t cursor_expected_q[$];
    int      mismatch_count;
    int      stuck_cycles;
    int      long_stall_left;
    logic    idle_enable;

    joystick_view_cursor_accelerator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .axis_select (axis_select),
        .axis_value  (axis_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .contact_on  (contact_on),
        .bounds_hold (bounds_hold),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    // gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // strong horizontal or vertical deflection, magnitude 96 or more
    function automatic logic [7:0] strong_push();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(224, 255));
        else
            return 8'($urandom_range(0, 32));
    endfunction

    // cursor update for one accepted sample, returns the expected result beat
    function automatic jvca_pkg::result_t advance_cursor(input logic sel,
                                                         input logic [7:0] val);
        logic    centered;
        logic    contact;
        int      mag_h;
        int      mag_v;
        int      lvl;
        int      pace;
        int      st;
        int      px;
        int      py;
        jvca_pkg::result_t res;

        if (sel == AXIS_V) begin
            stick_v = val;
            defl_v  = 9'(int'(val) - 128);
        end else begin
            stick_h = val;
            defl_h  = 9'(int'(val) - 128);
        end

        centered = (stick_h == jvca_pkg::CENTER_RAW) && (stick_v == jvca_pkg::CENTER_RAW);
        if (centered) begin
            pos_x = 13'(home_x);
            pos_y = 13'(home_y);
        end

        mag_h = (defl_h < 0) ? -int'(defl_h) : int'(defl_h);
        mag_v = (defl_v < 0) ? -int'(defl_v) : int'(defl_v);

        if (defl_h == 0 && defl_v == 0) begin
            sustain_cnt = '0;
        end else begin
            // small vertical deflection counts as a pure horizontal push
            if (mag_v < int'(jvca_pkg::FLAT_LIMIT))
                defl_v = '0;

            lvl = int'(pace_level);
            if (lvl < 1)
                lvl = 1;
            if (lvl > 5)
                lvl = 5;
            case (lvl)
                1:       pace = 8;
                2:       pace = 6;
                3:       pace = 3;
                4:       pace = 2;
                default: pace = 1;
            endcase

            if (int'(pace_cnt) + 1 < pace) begin
                pace_cnt = pace_cnt + 3'd1;
            end else begin
                pace_cnt    = '0;
                sustain_cnt = sustain_cnt + 6'd1;
                if (sustain_cnt < 15)
                    st = 1;
                else if (sustain_cnt < 20)
                    st = 2;
                else if (sustain_cnt < 30)
                    st = 3;
                else if (sustain_cnt < 40)
                    st = 4;
                else if (sustain_cnt < 50)
                    st = 5;
                else if (sustain_cnt < 60)
                    st = 6;
                else
                    st = 7;
                if (sustain_cnt >= 60)
                    sustain_cnt = sustain_cnt - 6'd1;

                // weakening or weak horizontal push falls back to a slow step
                if (mag_h < int'(last_mag) || mag_h < int'(jvca_pkg::WEAK_LIMIT)) begin
                    sustain_cnt = 6'd15;
                    st          = 2;
                end
                last_mag = 8'(mag_h);

                px = int'(pos_x);
                py = int'(pos_y);
                if (defl_v == 0) begin
                    px = px + ((defl_h < 0) ? -st : st);
                end else if (defl_h == 0) begin
                    if (st > 3)
                        st = 3;
                    py = py + ((defl_v < 0) ? -st : st);
                end else begin
                    if (st > 3)
                        st = 2;
                    px = px + ((defl_h < 0) ? -st : st);
                    py = py + ((defl_v < 0) ? -st : st);
                end

                // leaving the right half of the screen snaps home
                if (py > jvca_pkg::SCREEN_HEIGHT || py < 0) begin
                    px      = int'(home_x);
                    py      = int'(home_y);
                    wrapped = 1'b1;
                end
                if (px < jvca_pkg::SCREEN_WIDTH / 2 + 2 || px > jvca_pkg::SCREEN_WIDTH) begin
                    px      = int'(home_x);
                    py      = int'(home_y);
                    wrapped = 1'b1;
                end
                pos_x = 13'(px);
                pos_y = 13'(py);
            end
        end

        // contact with post-wrap hold
        if (centered) begin
            contact = 1'b0;
        end else if (wrapped) begin
            hold_cnt = hold_cnt + 4'd1;
            if (hold_cnt < jvca_pkg::HOLD_SAMPLES) begin
                contact = 1'b0;
            end else begin
                hold_cnt = '0;
                wrapped  = 1'b0;
                contact  = 1'b1;
            end
        end else begin
            contact = 1'b1;
        end

        res.cursor_x    = pos_x[10:0];
        res.cursor_y    = pos_y[10:0];
        res.contact_on  = contact;
        res.bounds_hold = wrapped;
        return res;
    endfunction

    // one sample beat; entered and left at a falling edge
    task automatic send_sample(input logic sel, input logic [7:0] val);
        int gap;
        in_valid    <= 1'b1;
        axis_select <= sel;
        axis_value  <= val;
        do
            @(posedge clk);
        while (!in_ready);
        cursor_expected_q.push_back(advance_cursor(sel, val));
        @(negedge clk);
        gap = idle_enable ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop offering samples and wait for every result plus the pipeline tail
    task automatic quiesce();
        in_valid <= 1'b0;
        @(negedge clk);
        while (cursor_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_PAD) @(negedge clk);
    endtask

    // register write beat; only called while the block is idle
    task automatic write_register(input logic [1:0] idx, input logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            jvca_pkg::REG_SPEED_LEVEL: pace_level = data[2:0];
            jvca_pkg::REG_ORIGIN_X: begin
                home_x = data;
                pos_x  = 13'(home_x);
                pos_y  = 13'(home_y);
            end
            jvca_pkg::REG_ORIGIN_Y: begin
                home_y = data;
                pos_x  = 13'(home_x);
                pos_y  = 13'(home_y);
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one random gesture: mostly held pushes, some centering and noise
    task automatic send_gesture(output int sent);
        int         kind;
        int         len;
        logic [7:0] push_h;
        logic [7:0] push_v;
        sent = 0;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // held horizontal push with the odd near-flat vertical sample
            push_h = strong_push();
            len    = $urandom_range(10, 90);
            repeat (len) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_sample(AXIS_V, 8'($urandom_range(106, 150)));
                end else begin
                    if ($urandom_range(0, 11) == 0)
                        push_h = strong_push();
                    send_sample(AXIS_H, push_h);
                end
                sent++;
            end
        end else if (kind < 55) begin
            // vertical push with the horizontal axis parked
            push_v = strong_push();
            send_sample(AXIS_H, jvca_pkg::CENTER_RAW);
            len = $urandom_range(5, 30);
            repeat (len)
                send_sample(AXIS_V, push_v);
            sent = len + 1;
        end else if (kind < 70) begin
            // diagonal push
            push_h = strong_push();
            push_v = strong_push();
            len    = $urandom_range(4, 30);
            repeat (len) begin
                send_sample(AXIS_H, push_h);
                send_sample(AXIS_V, push_v);
            end
            sent = 2 * len;
        end else if (kind < 80) begin
            // release to center
            send_sample(AXIS_H, jvca_pkg::CENTER_RAW);
            send_sample(AXIS_V, jvca_pkg::CENTER_RAW);
            sent = 2;
        end else begin
            // noise
            len = $urandom_range(1, 20);
            repeat (len)
                send_sample(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            sent = len;
        end
    endtask

    // extremes of both axes, centering, flat vertical and zero offsets
    task automatic test_axis_extremes();
        write_register(jvca_pkg::REG_SPEED_LEVEL, 11'(jvca_pkg::SPEED_RESET));
        send_sample(AXIS_H, 8'd255);
        send_sample(AXIS_H, 8'd255);
        send_sample(AXIS_H, 8'd255);
        send_sample(AXIS_V, 8'd0);
        send_sample(AXIS_V, 8'd255);
        send_sample(AXIS_H, 8'd0);
        send_sample(AXIS_V, jvca_pkg::CENTER_RAW);
        send_sample(AXIS_H, jvca_pkg::CENTER_RAW);
        // flat vertical with parked horizontal moves toward positive x
        send_sample(AXIS_V, 8'd140);
        // both offsets zero while the vertical raw is off center
        send_sample(AXIS_H, jvca_pkg::CENTER_RAW);
        send_sample(AXIS_V, jvca_pkg::CENTER_RAW);
        quiesce();
    endtask

    // pacing levels, out of range levels and a level change mid count
    task automatic test_speed_levels();
        write_register(jvca_pkg::REG_SPEED_LEVEL, 11'(jvca_pkg::LEVEL_MIN));
        send_sample(AXIS_H, 8'd200);
        send_sample(AXIS_H, 8'd200);
        quiesce();
        write_register(jvca_pkg::REG_SPEED_LEVEL, 11'd4);
        send_sample(AXIS_H, 8'd200);
        quiesce();
        write_register(jvca_pkg::REG_SPEED_LEVEL, 11'd0);
        send_sample(AXIS_H, 8'd60);
        quiesce();
        write_register(jvca_pkg::REG_SPEED_LEVEL, 11'h7FF);
        send_sample(AXIS_H, 8'd60);
        quiesce();
    endtask

    // bounds wrap, centering during the hold, origin outside the screen
    task automatic test_origin_wrap();
        write_register(jvca_pkg::REG_SPEED_LEVEL, 11'(jvca_pkg::LEVEL_MAX));
        write_register(jvca_pkg::REG_ORIGIN_X, 11'(jvca_pkg::SCREEN_WIDTH));
        write_register(jvca_pkg::REG_ORIGIN_Y, 11'(jvca_pkg::SCREEN_HEIGHT));
        send_sample(AXIS_H, 8'd255);
        send_sample(AXIS_H, jvca_pkg::CENTER_RAW);
        send_sample(AXIS_V, 8'd0);
        quiesce();
        write_register(jvca_pkg::REG_ORIGIN_X, 11'd0);
        write_register(jvca_pkg::REG_ORIGIN_Y, 11'h7FF);
        write_register(REG_UNUSED, 11'h5A5);
        send_sample(AXIS_H, 8'd10);
        send_sample(AXIS_H, 8'd10);
        quiesce();
        write_register(jvca_pkg::REG_ORIGIN_X, jvca_pkg::ORIGIN_X_RESET);
        write_register(jvca_pkg::REG_ORIGIN_Y, jvca_pkg::ORIGIN_Y_RESET);
    endtask

    // long receiver hold-off while samples keep coming back to back
    task automatic test_output_backpressure();
        int sent;
        int total;
        total       = 0;
        idle_enable = 1'b0;
        long_stall_left = 300;
        while (total < 60) begin
            send_gesture(sent);
            total += sent;
        end
        idle_enable = 1'b1;
        quiesce();
    endtask

    // sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        int sent;
        int total;
        repeat (3) begin
            total = 0;
            while (total < 20) begin
                send_gesture(sent);
                total += sent;
            end
            quiesce();
        end
    endtask

    // random phases, each under a fresh register setting
    task automatic test_random_traffic(input int n_items);
        int         total;
        int         phase_total;
        int         sent;
        int         r;
        logic [2:0] lvl;
        logic [10:0] ox;
        logic [10:0] oy;
        total = 0;
        while (total < n_items) begin
            quiesce();
            r = $urandom_range(0, 99);
            if (r < 70)
                lvl = 3'($urandom_range(1, 5));
            else
                lvl = 3'($urandom_range(0, 7));
            write_register(jvca_pkg::REG_SPEED_LEVEL, {8'($urandom_range(0, 255)), lvl});

            r = $urandom_range(0, 99);
            if (r < 75)
                ox = 11'($urandom_range(jvca_pkg::SCREEN_WIDTH / 2 + 2, jvca_pkg::SCREEN_WIDTH));
            else if (r < 90)
                ox = $urandom_range(0, 1) ? 11'(jvca_pkg::SCREEN_WIDTH)
                                          : 11'(jvca_pkg::SCREEN_WIDTH / 2 + 2);
            else
                ox = 11'($urandom_range(0, 2047));
            r = $urandom_range(0, 99);
            if (r < 75)
                oy = 11'($urandom_range(0, jvca_pkg::SCREEN_HEIGHT));
            else if (r < 90)
                oy = $urandom_range(0, 1) ? 11'(jvca_pkg::SCREEN_HEIGHT) : 11'd0;
            else
                oy = 11'($urandom_range(0, 2047));
            write_register(jvca_pkg::REG_ORIGIN_X, ox);
            write_register(jvca_pkg::REG_ORIGIN_Y, oy);
            if ($urandom_range(0, 9) == 0)
                write_register(REG_UNUSED, 11'($urandom_range(0, 2047)));

            // some phases run with no idling on either side
            idle_enable = ($urandom_range(0, 4) != 0);
            phase_total = 0;
            while (phase_total < 120) begin
                send_gesture(sent);
                phase_total += sent;
            end
            total += phase_total;
        end
        idle_enable = 1'b1;
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // result beat check against the oldest expectation
    always @(posedge clk) begin : result_check
        jvca_pkg::result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (cursor_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP)
                    $display("%0t: unexpected result expected none actual x=%0d y=%0d c=%0d h=%0d",
                             $time, cursor_x, cursor_y, contact_on, bounds_hold);
            end else begin
                want = cursor_expected_q.pop_front();
                compare_field("cursor_x", want.cursor_x, cursor_x);
                compare_field("cursor_y", want.cursor_y, cursor_y);
                compare_field("contact_on", want.contact_on, contact_on);
                compare_field("bounds_hold", want.bounds_hold, bounds_hold);
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial begin : result_sink
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_stall_left > 0) begin
                out_ready <= 1'b0;
                long_stall_left--;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                out_ready  <= 1'b0;
                stall_left = gap_len();
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        axis_select     = AXIS_H;
        axis_value      = jvca_pkg::CENTER_RAW;
        cfg_valid       = 1'b0;
        cfg_index       = jvca_pkg::REG_SPEED_LEVEL;
        cfg_data        = '0;
        idle_enable     = 1'b1;
        long_stall_left = 0;
        mismatch_count  = 0;
        stuck_cycles    = 0;

        // predictor at its reset state
        pace_level  = jvca_pkg::SPEED_RESET;
        home_x      = jvca_pkg::ORIGIN_X_RESET;
        home_y      = jvca_pkg::ORIGIN_Y_RESET;
        stick_h     = jvca_pkg::CENTER_RAW;
        stick_v     = jvca_pkg::CENTER_RAW;
        defl_h      = '0;
        defl_v      = '0;
        pace_cnt    = '0;
        sustain_cnt = '0;
        last_mag    = '0;
        pos_x       = 13'(jvca_pkg::ORIGIN_X_RESET);
        pos_y       = 13'(jvca_pkg::ORIGIN_Y_RESET);
        wrapped     = 1'b0;
        hold_cnt    = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_axis_extremes();
        test_speed_levels();
        test_origin_wrap();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(950);

        quiesce();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
